### sv/assert_macros.svh
// Assertion helpers used by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pcx_pkg.sv
`timescale 1ns / 1ps

package pcx_pkg;

    // Largest image the pixel counter must hold.
    localparam int MAX_WIDTH  = 320;
    localparam int MAX_HEIGHT = 256;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPAND_RGB   = 2'd2;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 9'd320;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 9'd200;

    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int PIX_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int RUN_W  = 6;
    localparam int WCMP_W = (CFG_W > WID_W) ? CFG_W : WID_W;
    localparam int HCMP_W = (CFG_W > HGT_W) ? CFG_W : HGT_W;
    localparam int RCMP_W = (PIX_W > RUN_W) ? PIX_W : RUN_W;

    localparam logic [7:0] RUN_MARK = 8'hC0;
    localparam logic [7:0] RUN_MASK = 8'h3F;

    // Input item kinds.
    localparam logic [1:0] KIND_PALETTE = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_DATA    = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERRUN = 2'd1;
    localparam logic [1:0] ST_EARLY   = 2'd2;

    typedef struct packed {
        logic        wr_en;
        logic [7:0]  wr_addr;
        logic [23:0] wr_data;
        logic        rd_en;
        logic [7:0]  rd_addr;
    } pal_ctrl_t;

endpackage

### sv/pcx_rle_pixel_decoder.sv
`timescale 1ns / 1ps

// 8-bit PCX run-length decoder. Each input item is a palette write, an
// image start, one compressed byte or an end-of-data marker. Pixels leave
// in raster order, one per cycle within a run while the output is not
// stalled, as a palette index and, when expand_rgb is set, as red, green
// and blue from the internal 256-entry palette. End of data gives one report
// item whose status tells whether the image was complete (0), a run overran
// it (1) or data ended early (2). The block works on one item at a time and
// drops in_ready while busy: a literal byte is accepted and then gives its
// pixel, a run marker byte arms the run and the next byte gives its pixels,
// an end-of-data item is accepted and then gives the report, and an image
// start steps through the bits of the clamped height (at most 9) because
// the width times height product is formed by shift and add on the same
// adder that counts pixels down. Palette writes, ignored bytes and run
// markers leave the block idle; a stalled output holds it in its run or
// report state. Palette entries read as garbage until written. Configuration
// registers are written through cfg_write, cfg_index and cfg_data.
module pcx_rle_pixel_decoder
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_write,
    input  logic [pcx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcx_pkg::CFG_W-1:0]        cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       kind,
    input  logic [7:0]                       data_byte,
    input  logic [7:0]                       palette_slot,
    input  logic [7:0]                       palette_red,
    input  logic [7:0]                       palette_green,
    input  logic [7:0]                       palette_blue,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             is_report,
    output logic [7:0]                       pixel_index,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic                             last_of_run,
    output logic                             image_done,
    output logic [1:0]                       status
);

    localparam int PIX_W  = pcx_pkg::PIX_W;
    localparam int HGT_W  = pcx_pkg::HGT_W;
    localparam int RUN_W  = pcx_pkg::RUN_W;
    localparam int CFG_W  = pcx_pkg::CFG_W;
    localparam int WCMP_W = pcx_pkg::WCMP_W;
    localparam int HCMP_W = pcx_pkg::HCMP_W;
    localparam int RCMP_W = pcx_pkg::RCMP_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MUL    = 2'd1;
    localparam logic [1:0] S_RUN    = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    // Configuration registers.
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic             expand_reg, expand_next;

    // Decoder state.
    logic [1:0]       state_reg, state_next;
    logic [PIX_W-1:0] pixels_left_reg, pixels_left_next;
    logic [RUN_W-1:0] pending_run_reg, pending_run_next;
    logic             run_armed_reg, run_armed_next;
    logic [1:0]       error_code_reg, error_code_next;
    logic [RUN_W-1:0] run_cnt_reg, run_cnt_next;
    logic             overrun_reg, overrun_next;
    logic [7:0]       byte_reg, byte_next;
    logic [PIX_W-1:0] mcand_reg, mcand_next;
    logic [HGT_W-1:0] mplier_reg, mplier_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic             is_report_reg, is_report_next;
    logic [7:0]       index_reg, index_next;
    logic [7:0]       red_reg, red_next;
    logic [7:0]       green_reg, green_next;
    logic [7:0]       blue_reg, blue_next;
    logic             last_reg, last_next;
    logic             done_reg, done_next;
    logic [1:0]       status_reg, status_next;

    pcx_pkg::pal_ctrl_t pal_ctrl;
    logic [23:0]        pal_rd_data;
    logic [PIX_W-1:0]   alu_b;
    logic [PIX_W-1:0]   alu_sum;

    logic [WCMP_W-1:0]  width_ext;
    logic [HCMP_W-1:0]  height_ext;
    logic [PIX_W-1:0]   width_clamped;
    logic [HGT_W-1:0]   height_clamped;
    logic               run_too_long;
    logic               slot_free;
    logic               pixel_is_last;
    logic [1:0]         report_status;

    pcx_palette u_palette
    (
        .clk     (clk),
        .ctrl    (pal_ctrl),
        .rd_data (pal_rd_data)
    );

    pcx_alu u_alu
    (
        .a   (pixels_left_reg),
        .b   (alu_b),
        .sum (alu_sum)
    );

    // Image size is clamped to 1..MAX when an image starts.
    always_comb
    begin
        width_ext  = WCMP_W'(width_reg);
        height_ext = HCMP_W'(height_reg);
        if (width_ext == '0)
        begin
            width_clamped = PIX_W'(1);
        end
        else if (width_ext > WCMP_W'(pcx_pkg::MAX_WIDTH))
        begin
            width_clamped = PIX_W'(pcx_pkg::MAX_WIDTH);
        end
        else
        begin
            width_clamped = PIX_W'(width_ext);
        end
        if (height_ext == '0)
        begin
            height_clamped = HGT_W'(1);
        end
        else if (height_ext > HCMP_W'(pcx_pkg::MAX_HEIGHT))
        begin
            height_clamped = HGT_W'(pcx_pkg::MAX_HEIGHT);
        end
        else
        begin
            height_clamped = HGT_W'(height_ext);
        end
    end

    // A run longer than the pixels still expected is cut and flagged.
    assign run_too_long  = RCMP_W'(pending_run_reg) > RCMP_W'(pixels_left_reg);
    assign slot_free     = !out_valid_reg || out_ready;
    assign pixel_is_last = (run_cnt_reg == RUN_W'(1)) || (pixels_left_reg == PIX_W'(1));
    assign report_status = (error_code_reg != pcx_pkg::ST_OK) ? error_code_reg :
                           (pixels_left_reg != '0) ? pcx_pkg::ST_EARLY : pcx_pkg::ST_OK;

    // Configuration writes.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        expand_next = expand_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                pcx_pkg::CFG_IMAGE_WIDTH:  width_next  = cfg_data;
                pcx_pkg::CFG_IMAGE_HEIGHT: height_next = cfg_data;
                pcx_pkg::CFG_EXPAND_RGB:   expand_next = cfg_data[0];
                default:                   expand_next = expand_reg;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        pixels_left_next = pixels_left_reg;
        pending_run_next = pending_run_reg;
        run_armed_next   = run_armed_reg;
        error_code_next  = error_code_reg;
        run_cnt_next     = run_cnt_reg;
        overrun_next     = overrun_reg;
        byte_next        = byte_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;

        out_valid_next   = out_valid_reg && !out_ready;
        is_report_next   = is_report_reg;
        index_next       = index_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        last_next        = last_reg;
        done_next        = done_reg;
        status_next      = status_reg;

        pal_ctrl         = '0;
        alu_b            = '1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        pcx_pkg::KIND_PALETTE:
                        begin
                            pal_ctrl.wr_en   = 1'b1;
                            pal_ctrl.wr_addr = palette_slot;
                            pal_ctrl.wr_data = {palette_red, palette_green, palette_blue};
                        end
                        pcx_pkg::KIND_START:
                        begin
                            mcand_next       = width_clamped;
                            mplier_next      = height_clamped;
                            pixels_left_next = '0;
                            pending_run_next = '0;
                            run_armed_next   = 1'b0;
                            error_code_next  = pcx_pkg::ST_OK;
                            state_next       = S_MUL;
                        end
                        pcx_pkg::KIND_DATA:
                        begin
                            byte_next        = data_byte;
                            pal_ctrl.rd_en   = 1'b1;
                            pal_ctrl.rd_addr = data_byte;
                            if (pixels_left_reg != '0)
                            begin
                                if (run_armed_reg)
                                begin
                                    run_armed_next   = 1'b0;
                                    pending_run_next = '0;
                                    if (pending_run_reg != '0)
                                    begin
                                        run_cnt_next = pending_run_reg;
                                        overrun_next = run_too_long;
                                        if (run_too_long)
                                        begin
                                            error_code_next = pcx_pkg::ST_OVERRUN;
                                        end
                                        state_next = S_RUN;
                                    end
                                end
                                else if ((data_byte & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK)
                                begin
                                    pending_run_next = RUN_W'(data_byte & pcx_pkg::RUN_MASK);
                                    run_armed_next   = 1'b1;
                                end
                                else
                                begin
                                    run_cnt_next = RUN_W'(1);
                                    overrun_next = 1'b0;
                                    state_next   = S_RUN;
                                end
                            end
                        end
                        pcx_pkg::KIND_END:
                        begin
                            state_next = S_REPORT;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                // One multiplier bit per cycle, accumulated into the counter.
                alu_b            = mplier_reg[0] ? mcand_reg : '0;
                pixels_left_next = alu_sum;
                mcand_next       = mcand_reg << 1;
                mplier_next      = mplier_reg >> 1;
                if ((mplier_reg >> 1) == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RUN:
            begin
                if (slot_free)
                begin
                    alu_b            = '1;
                    pixels_left_next = alu_sum;
                    run_cnt_next     = run_cnt_reg - RUN_W'(1);
                    out_valid_next   = 1'b1;
                    is_report_next   = 1'b0;
                    index_next       = byte_reg;
                    red_next         = expand_reg ? pal_rd_data[23:16] : 8'd0;
                    green_next       = expand_reg ? pal_rd_data[15:8] : 8'd0;
                    blue_next        = expand_reg ? pal_rd_data[7:0] : 8'd0;
                    last_next        = pixel_is_last;
                    done_next        = (pixels_left_reg == PIX_W'(1));
                    status_next      = overrun_reg ? pcx_pkg::ST_OVERRUN : pcx_pkg::ST_OK;
                    if (pixel_is_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REPORT:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    is_report_next   = 1'b1;
                    index_next       = 8'd0;
                    red_next         = 8'd0;
                    green_next       = 8'd0;
                    blue_next        = 8'd0;
                    last_next        = 1'b1;
                    done_next        = 1'b0;
                    status_next      = report_status;
                    error_code_next  = report_status;
                    pixels_left_next = '0;
                    pending_run_next = '0;
                    run_armed_next   = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= pcx_pkg::RESET_WIDTH;
            height_reg      <= pcx_pkg::RESET_HEIGHT;
            expand_reg      <= 1'b1;
            state_reg       <= S_IDLE;
            pixels_left_reg <= '0;
            pending_run_reg <= '0;
            run_armed_reg   <= 1'b0;
            error_code_reg  <= pcx_pkg::ST_OK;
            run_cnt_reg     <= '0;
            overrun_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            width_reg       <= width_next;
            height_reg      <= height_next;
            expand_reg      <= expand_next;
            state_reg       <= state_next;
            pixels_left_reg <= pixels_left_next;
            pending_run_reg <= pending_run_next;
            run_armed_reg   <= run_armed_next;
            error_code_reg  <= error_code_next;
            run_cnt_reg     <= run_cnt_next;
            overrun_reg     <= overrun_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        is_report_reg <= is_report_next;
        index_reg     <= index_next;
        red_reg       <= red_next;
        green_reg     <= green_next;
        blue_reg      <= blue_next;
        last_reg      <= last_next;
        done_reg      <= done_next;
        status_reg    <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign is_report   = is_report_reg;
    assign pixel_index = index_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign last_of_run = last_reg;
    assign image_done  = done_reg;
    assign status      = status_reg;

`include "assert_macros.svh"

    // A run is only entered with pixels outstanding, and it ends on the last one.
    `ASSERT_SAME(a_run_has_pixels, clk, rst_n, state_reg == S_RUN, pixels_left_reg != '0, "run state with no pixels left")

    `ASSERT_SAME(a_run_has_count, clk, rst_n, state_reg == S_RUN, run_cnt_reg != '0, "run state with empty run counter")

    // The pixel that finishes the image leaves the counter at zero and ends the run.
    `ASSERT_NEXT(a_done_clears, clk, rst_n, state_reg == S_RUN && slot_free && pixels_left_reg == PIX_W'(1), pixels_left_reg == '0 && state_reg == S_IDLE && image_done, "final pixel did not close the image")

endmodule

### sv/pcx_palette.sv
`timescale 1ns / 1ps

module pcx_palette
(
    input  logic               clk,
    input  pcx_pkg::pal_ctrl_t ctrl,
    output logic [23:0]        rd_data
);

    logic [23:0] mem [0:255];
    logic [23:0] rd_data_reg;

    // Entries hold garbage until written; no reset is needed.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/pcx_alu.sv
`timescale 1ns / 1ps

// Shared adder for the pixel counter: accumulates partial products while
// an image starts and counts down by one for every pixel sent.
module pcx_alu
(
    input  logic [pcx_pkg::PIX_W-1:0] a,
    input  logic [pcx_pkg::PIX_W-1:0] b,
    output logic [pcx_pkg::PIX_W-1:0] sum
);

    assign sum = a + b;

endmodule

### tb/pcx_rle_pixel_decoder_tb.sv
`timescale 1ns / 1ps

module pcx_rle_pixel_decoder_tb;

    // Number of useful items sent by the random part.
    localparam int RANDOM_ITEMS = 120;
    // Palette entries loaded up front; pixels in expand mode only use these.
    localparam int PALETTE_SLOTS = 48;
    // Cycles allowed after the last expected result. An image start forms
    // width times height and gives no result, so this must cover it before
    // any register write.
    localparam int SETTLE_CYCLES = 16;
    // Length of the long receiver hold-off in the back-pressure test.
    localparam int HOLD_CYCLES = 400;

    // One input item as the sender sees it.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  slot;
        logic [23:0] rgb;
    } rle_cmd_t;

    // One result item: a decoded pixel or an end-of-data report.
    typedef struct packed {
        logic       is_report;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_run;
        logic       image_done;
        logic [1:0] status;
    } dec_out_t;

    // Shapes of a random compressed stream.
    typedef enum int {
        STREAM_CLEAN,
        STREAM_OVERRUN,
        STREAM_EARLY,
        STREAM_NOISY
    } stream_style_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                          cfg_write = 1'b0;
    logic [pcx_pkg::CFG_IDX_W-1:0] cfg_index = pcx_pkg::CFG_IMAGE_WIDTH;
    logic [pcx_pkg::CFG_W-1:0]     cfg_data  = '0;

    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [1:0] kind          = pcx_pkg::KIND_PALETTE;
    logic [7:0] data_byte     = 8'd0;
    logic [7:0] palette_slot  = 8'd0;
    logic [7:0] palette_red   = 8'd0;
    logic [7:0] palette_green = 8'd0;
    logic [7:0] palette_blue  = 8'd0;

    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       is_report;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_run;
    logic       image_done;
    logic [1:0] status;

    // Our own copy of the decoder state and its registers.
    logic [23:0] palette_copy [256];
    int unsigned pixels_left_copy = 0;
    logic [5:0]  run_count_copy   = '0;
    logic        run_armed_copy   = 1'b0;
    logic [1:0]  image_err_copy   = pcx_pkg::ST_OK;
    logic [8:0]  width_reg        = pcx_pkg::RESET_WIDTH;
    logic [8:0]  height_reg       = pcx_pkg::RESET_HEIGHT;
    logic        expand_reg       = 1'b1;

    // Results still owed by the block, oldest first.
    dec_out_t decoded_due [$];

    // Idle mix: percent chance per cycle that the sender waits or the
    // receiver stalls. hold_left forces a long stall when set.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;

    int errors          = 0;
    int items_used      = 0;
    int images_started  = 0;
    int ignored_bytes   = 0;
    int cut_runs        = 0;
    int pixels_checked  = 0;
    int reports_checked = 0;

    pcx_rle_pixel_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .data_byte     (data_byte),
        .palette_slot  (palette_slot),
        .palette_red   (palette_red),
        .palette_green (palette_green),
        .palette_blue  (palette_blue),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_report     (is_report),
        .pixel_index   (pixel_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .last_of_run   (last_of_run),
        .image_done    (image_done),
        .status        (status)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The size registers are clamped into the supported range when an
    // image starts, so out-of-range values still give a usable image.
    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Loaded palette entries come in three groups of sixteen: the bottom of
    // the byte range, the top of the literal range and the top of the byte
    // range.
    function automatic logic [7:0] loaded_slot(input int unsigned i);
        if (i < 16)
            return 8'(i);
        if (i < 32)
            return 8'(32'hB0 + (i - 32'd16));
        return 8'(32'hF0 + (i - 32'd32));
    endfunction

    // A literal pixel byte. With colours on it is one of the loaded entries.
    function automatic logic [7:0] pick_literal();
        if (expand_reg)
            return loaded_slot($urandom_range(31));
        return 8'($urandom_range(8'hBF));
    endfunction

    // The byte repeated by a run. With colours on it is a loaded entry.
    function automatic logic [7:0] pick_run_byte();
        if (expand_reg)
            return loaded_slot($urandom_range(PALETTE_SLOTS - 1));
        return 8'($urandom);
    endfunction

    // Queue one decoded pixel. The colour is looked up now, since the block
    // takes no new item (and so no palette write) while a run drains.
    function automatic void queue_pixel(input logic [7:0] idx, input logic last,
                                        input logic done, input logic [1:0] st);
        logic [23:0] rgb;
        rgb = expand_reg ? palette_copy[idx] : 24'd0;
        decoded_due.push_back({1'b0, idx, rgb, last, done, st});
    endfunction

    // Advance our copy of the decoder by one accepted item and queue every
    // result that the item causes.
    function automatic void decode_item(input rle_cmd_t c);
        int unsigned n;
        int unsigned k;
        logic [1:0]  st;
        items_used++;
        case (c.kind)
            pcx_pkg::KIND_PALETTE:
            begin
                palette_copy[c.slot] = c.rgb;
            end
            pcx_pkg::KIND_START:
            begin
                pixels_left_copy = clamp_size(width_reg, pcx_pkg::MAX_WIDTH) *
                                   clamp_size(height_reg, pcx_pkg::MAX_HEIGHT);
                run_count_copy = '0;
                run_armed_copy = 1'b0;
                image_err_copy = pcx_pkg::ST_OK;
                images_started++;
            end
            pcx_pkg::KIND_END:
            begin
                // A sticky error wins; otherwise missing pixels (an armed
                // marker included) mean the data ended early.
                st = image_err_copy;
                if (st == pcx_pkg::ST_OK && pixels_left_copy != 0)
                    st = pcx_pkg::ST_EARLY;
                decoded_due.push_back({1'b1, 8'd0, 24'd0, 1'b1, 1'b0, st});
                image_err_copy = st;
                pixels_left_copy = 0;
                run_count_copy = '0;
                run_armed_copy = 1'b0;
            end
            default:
            begin
                if (pixels_left_copy == 0)
                begin
                    // No image open: the byte is dropped.
                    ignored_bytes++;
                    items_used--;
                end
                else if (run_armed_copy)
                begin
                    n = run_count_copy;
                    st = pcx_pkg::ST_OK;
                    run_armed_copy = 1'b0;
                    run_count_copy = '0;
                    if (n > pixels_left_copy)
                    begin
                        // The run is cut at the last pixel and every pixel
                        // of it carries the overrun status.
                        n = pixels_left_copy;
                        st = pcx_pkg::ST_OVERRUN;
                        image_err_copy = pcx_pkg::ST_OVERRUN;
                        cut_runs++;
                    end
                    for (k = 0; k < n; k++)
                    begin
                        pixels_left_copy--;
                        queue_pixel(c.data_byte, k + 1 == n, pixels_left_copy == 0, st);
                    end
                end
                else if ((c.data_byte & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK)
                begin
                    run_count_copy = 6'(c.data_byte & pcx_pkg::RUN_MASK);
                    run_armed_copy = 1'b1;
                end
                else
                begin
                    pixels_left_copy--;
                    queue_pixel(c.data_byte, 1'b1, pixels_left_copy == 0, pcx_pkg::ST_OK);
                end
            end
        endcase
    endfunction

    // Offer one item and wait for it to be taken. Valid is left high on
    // return: the caller either sends the next item at once or lowers it.
    task automatic send_cmd(input logic [1:0] k, input logic [7:0] b,
                            input logic [7:0] slot, input logic [23:0] rgb);
        rle_cmd_t c;
        c = {k, b, slot, rgb};
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        kind <= k;
        data_byte <= b;
        palette_slot <= slot;
        {palette_red, palette_green, palette_blue} <= rgb;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_item(c);
    endtask

    // The fields that an item kind does not use still carry random values.
    task automatic send_byte(input logic [7:0] b);
        send_cmd(pcx_pkg::KIND_DATA, b, 8'($urandom), 24'($urandom));
    endtask

    task automatic send_start();
        send_cmd(pcx_pkg::KIND_START, 8'($urandom), 8'($urandom), 24'($urandom));
    endtask

    task automatic send_end();
        send_cmd(pcx_pkg::KIND_END, 8'($urandom), 8'($urandom), 24'($urandom));
    endtask

    task automatic send_palette(input logic [7:0] slot, input logic [23:0] rgb);
        send_cmd(pcx_pkg::KIND_PALETTE, 8'($urandom), slot, rgb);
    endtask

    // Stop offering items and wait until every owed result has come, then
    // give the block time to finish an item that causes no result.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Write all three registers on back-to-back cycles. Only called when the
    // block is idle.
    task automatic set_geometry(input logic [8:0] w, input logic [8:0] h, input logic rgb);
        cfg_write <= 1'b1;
        cfg_index <= pcx_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= pcx_pkg::CFG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_index <= pcx_pkg::CFG_EXPAND_RGB;
        cfg_data <= {8'd0, rgb};
        @(posedge clk);
        cfg_write <= 1'b0;
        width_reg = w;
        height_reg = h;
        expand_reg = rgb;
    endtask

    task automatic note_mismatch(input string field, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
        errors++;
    endtask

    // Compare one taken result with the oldest expectation, field by field.
    task automatic check_result();
        dec_out_t got;
        dec_out_t want;
        got = {is_report, pixel_index, red, green, blue, last_of_run, image_done, status};
        if (decoded_due.size() == 0)
        begin
            $display("%0t: result with none expected, expected nothing, actual %h",
                     $time, got);
            errors++;
        end
        else
        begin
            want = decoded_due.pop_front();
            if (got.is_report !== want.is_report)
                note_mismatch("is_report", want.is_report, got.is_report);
            if (got.pixel_index !== want.pixel_index)
                note_mismatch("pixel_index", want.pixel_index, got.pixel_index);
            if (got.red !== want.red)
                note_mismatch("red", want.red, got.red);
            if (got.green !== want.green)
                note_mismatch("green", want.green, got.green);
            if (got.blue !== want.blue)
                note_mismatch("blue", want.blue, got.blue);
            if (got.last_of_run !== want.last_of_run)
                note_mismatch("last_of_run", want.last_of_run, got.last_of_run);
            if (got.image_done !== want.image_done)
                note_mismatch("image_done", want.image_done, got.image_done);
            if (got.status !== want.status)
                note_mismatch("status", want.status, got.status);
            if (want.is_report)
                reports_checked++;
            else
                pixels_checked++;
        end
    endtask

    // Receiver: check what was taken at this edge, then choose ready for the
    // next cycle. A pending hold-off is counted down here, one per cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result();
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Load the palette entries that pixels may use while colours are on.
    // Entry 0 and entry 255 hold the colour extremes.
    task automatic test_palette_load();
        int unsigned i;
        logic [7:0]  slot;
        send_idle_pct = 0;
        stall_pct = 0;
        for (i = 0; i < PALETTE_SLOTS; i++)
        begin
            slot = loaded_slot(i);
            if (slot == 8'h00)
                send_palette(slot, 24'h000000);
            else if (slot == 8'hFF)
                send_palette(slot, 24'hFFFFFF);
            else
                send_palette(slot, 24'($urandom));
        end
    endtask

    // Hand-built streams through a 4 by 2 image that hit each special case.
    task automatic test_directed_stream();
        // A byte with no image open is dropped, and a report with no image
        // says all is well.
        send_byte(8'h12);
        send_end();
        drain_results();
        set_geometry(9'd4, 9'd2, 1'b1);
        send_start();
        // Smallest and largest literal pixels.
        send_byte(8'h00);
        send_byte(8'hBF);
        // A zero-length run eats its byte and gives nothing.
        send_byte(pcx_pkg::RUN_MARK);
        send_byte(8'hAA);
        send_byte(pcx_pkg::RUN_MARK | 8'd3);
        send_byte(8'hFF);
        // The longest run overruns the three pixels left and is cut.
        send_byte(pcx_pkg::RUN_MARK | pcx_pkg::RUN_MASK);
        send_byte(8'hF5);
        // The image is full: this byte is dropped, and the overrun status
        // sticks through a repeated report.
        send_byte(8'h33);
        send_end();
        send_end();
        drain_results();
        // Index-only mode, and a report with a marker still armed.
        set_geometry(9'd4, 9'd2, 1'b0);
        send_start();
        send_byte(8'h7F);
        send_byte(pcx_pkg::RUN_MARK | 8'd1);
        send_end();
    endtask

    // Sizes outside the supported range are clamped at image start.
    task automatic test_size_clamping();
        drain_results();
        // Zero by zero becomes one pixel; the run data byte looks like a
        // marker but is taken as the pixel.
        set_geometry(9'd0, 9'd0, 1'b1);
        send_start();
        send_byte(pcx_pkg::RUN_MARK | 8'd1);
        send_byte(8'hFA);
        send_end();
        drain_results();
        set_geometry(9'h1FF, 9'h1FF, 1'b1);
        send_start();
        send_byte(8'hB4);
        send_end();
        drain_results();
        set_geometry(9'(pcx_pkg::MAX_WIDTH), 9'(pcx_pkg::MAX_HEIGHT), 1'b0);
        send_start();
        send_byte(pcx_pkg::RUN_MARK | pcx_pkg::RUN_MASK);
        send_byte(8'h80);
        send_end();
    endtask

    // The receiver holds off for a long stretch while long runs keep coming,
    // so the block backs up and stops taking items.
    task automatic test_backpressure();
        drain_results();
        send_idle_pct = 0;
        stall_pct = 0;
        set_geometry(9'd20, 9'd10, 1'b1);
        send_start();
        hold_left = HOLD_CYCLES;
        repeat (3)
        begin
            send_byte(pcx_pkg::RUN_MARK | pcx_pkg::RUN_MASK);
            send_byte(pick_run_byte());
        end
        send_byte(8'h0E);
        send_byte(8'hB9);
        send_end();
        drain_results();
    endtask

    // Random images, mostly well formed with random content. Each image uses
    // the next idle mix in turn.
    task automatic test_random_images();
        int unsigned   first;
        int unsigned   img;
        int unsigned   total;
        int unsigned   budget;
        int unsigned   n;
        int unsigned   roll;
        logic [8:0]    w;
        logic [8:0]    h;
        stream_style_t style;
        first = items_used;
        img = 0;
        while (items_used - first < RANDOM_ITEMS)
        begin
            drain_results();
            case (img % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 79;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 79;
                end
                default:
                begin
                    send_idle_pct = 7;
                    stall_pct = 7;
                end
            endcase
            img++;

            // Now and then an extreme size; most images are small enough to
            // fill completely in a few dozen items.
            if ($urandom_range(15) == 0)
            begin
                case ($urandom_range(3))
                    0: w = 9'd0;
                    1: w = 9'd1;
                    2: w = 9'(pcx_pkg::MAX_WIDTH);
                    default: w = 9'h1FF;
                endcase
                case ($urandom_range(3))
                    0: h = 9'd0;
                    1: h = 9'd1;
                    2: h = 9'(pcx_pkg::MAX_HEIGHT);
                    default: h = 9'h1FF;
                endcase
            end
            else
            begin
                w = 9'($urandom_range(1, 24));
                h = 9'($urandom_range(1, 6));
            end
            set_geometry(w, h, 1'($urandom_range(1)));
            send_start();
            total = clamp_size(w, pcx_pkg::MAX_WIDTH) * clamp_size(h, pcx_pkg::MAX_HEIGHT);

            roll = $urandom_range(9);
            style = (roll < 5) ? STREAM_CLEAN :
                    (roll < 7) ? STREAM_OVERRUN :
                    (roll < 9) ? STREAM_EARLY : STREAM_NOISY;
            if (total > 200)
                style = STREAM_EARLY;
            if (style == STREAM_EARLY)
                budget = $urandom_range((total > 60) ? 60 : total - 1);
            else
                budget = total;

            // A noisy stream starts over after a few pixels.
            if (style == STREAM_NOISY)
            begin
                repeat ($urandom_range(1, 3))
                    send_byte(pick_literal());
                send_start();
            end

            while (budget > 0)
            begin
                roll = $urandom_range(99);
                if (roll < 6)
                    send_palette(8'($urandom), 24'($urandom));
                else if (roll < 50)
                begin
                    send_byte(pick_literal());
                    budget--;
                end
                else
                begin
                    // Runs fit what is left unless this stream is meant to
                    // overrun.
                    n = $urandom_range(63);
                    if (style != STREAM_OVERRUN && n > budget)
                        n = $urandom_range(budget);
                    send_byte(pcx_pkg::RUN_MARK | 8'(n));
                    send_byte(pick_run_byte());
                    budget = (n >= budget) ? 0 : budget - n;
                end
            end

            if (style == STREAM_EARLY && $urandom_range(1) == 1)
                send_byte(pcx_pkg::RUN_MARK | 8'($urandom_range(63)));
            if (style == STREAM_NOISY)
            begin
                send_byte(8'($urandom));
                send_end();
                send_byte(8'($urandom));
            end
            send_end();
        end
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_palette_load();
        test_directed_stream();
        test_size_clamping();
        test_backpressure();
        test_random_images();
        drain_results();
        $display("Decoded %0d images: %0d pixels and %0d end reports checked, %0d runs cut.",
                 images_started, pixels_checked, reports_checked, cut_runs);
        $display("%0d bytes dropped with no image open; idle mixes none, 79/0, 0/79, 7/7.",
                 ignored_bytes);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Guard against a hang: a correct run ends far sooner than this.
    initial
    begin
        #10_000_000;
        $display("%0t: run did not finish in time, %0d results outstanding",
                 $time, decoded_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### pcx_rle_pixel_decoder.f
+incdir+sv
sv/pcx_pkg.sv
sv/pcx_palette.sv
sv/pcx_alu.sv
sv/pcx_rle_pixel_decoder.sv
tb/pcx_rle_pixel_decoder_tb.sv
